### sv/elevator_scan_controller_assert.svh
// Assertion macros for the elevator scan controller checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ELEVATOR_SCAN_CONTROLLER_ASSERT_SVH
`define ELEVATOR_SCAN_CONTROLLER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define ESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elevator_scan_controller: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ESC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elevator_scan_controller: assertion failed");

`endif

### sv/esc_pkg.sv
// Shared types, codes and helper functions of the elevator scan controller.
// Used by the controller and by its checker; depends on nothing.
package esc_pkg;

  localparam int FLOOR_W    = 5;
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 3;
  localparam int MODE_W     = 2;
  localparam int DIR_W      = 2;
  localparam int DEF_FLOORS = 16;
  localparam int MAX_RES    = 4;
  localparam int RCNT_W     = 3;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [DIR_W-1:0]   dir_t;

  typedef struct packed {
    kind_t  kind;
    floor_t floor;
  } result_t;

  localparam cmd_t CMD_REQUEST = 2'd0;
  localparam cmd_t CMD_MOVED   = 2'd1;
  localparam cmd_t CMD_READY   = 2'd2;

  localparam kind_t EV_BUTTON = 3'd0;
  localparam kind_t EV_AT     = 3'd1;
  localparam kind_t EV_MOVE   = 3'd2;
  localparam kind_t EV_STOP   = 3'd3;
  localparam kind_t EV_LOCK   = 3'd4;

  localparam mode_t MODE_WAIT   = 2'd0;
  localparam mode_t MODE_TASK   = 2'd1;
  localparam mode_t MODE_MOVE   = 2'd2;
  localparam mode_t MODE_ARRIVE = 2'd3;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;

  // True when floor a lies strictly beyond floor b in the given direction.
  function automatic logic sweep_gt(floor_t a, floor_t b, dir_t dir);
    logic r;
    r = 1'b0;
    if (dir == DIR_UP) begin
      r = (a > b);
    end else if (dir == DIR_DOWN) begin
      r = (a < b);
    end
    return r;
  endfunction

endpackage

### sv/elevator_scan_controller.sv
// Elevator scan controller: mode, direction, floor and sweep-ordered target queue.
// Depends on esc_pkg; the target queue is a single-port-read memory inside this module.
//
// A command transfers when start is high and busy is low; busy then stays high until
// the last result of that command has been shown. Results appear one per cycle with
// strobe high for exactly one cycle each and last marking the final one; they cannot
// be held off, so a receiver must take every strobed cycle. A floor request scans the
// queue once, an insertion shifts the tail up and an arrival shifts the queue down;
// every scan and shift walks the queue one entry per cycle through the one read port
// of the queue memory. Requests for floors outside 1..FLOORS and unused commands
// transfer, produce no result, and then release busy.
module elevator_scan_controller #(
  parameter int FLOORS = esc_pkg::DEF_FLOORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  esc_pkg::cmd_t        cmd,
  input  esc_pkg::floor_t      req_floor,
  output logic                 busy,
  output logic                 strobe,
  output esc_pkg::kind_t       event_kind,
  output esc_pkg::floor_t      event_floor,
  output logic                 last
);

  localparam int AW = $clog2(FLOORS);
  localparam int QW = $clog2(FLOORS + 1);
  localparam esc_pkg::floor_t TOP_FLOOR = esc_pkg::floor_t'(FLOORS);
  localparam logic [QW-1:0]   QFULL     = QW'(FLOORS);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SCAN       = 3'd1;
  localparam logic [2:0] ST_DECIDE     = 3'd2;
  localparam logic [2:0] ST_SHIFT_UP   = 3'd3;
  localparam logic [2:0] ST_PLACE      = 3'd4;
  localparam logic [2:0] ST_ADVANCE    = 3'd5;
  localparam logic [2:0] ST_SHIFT_DOWN = 3'd6;
  localparam logic [2:0] ST_EMIT       = 3'd7;

  logic [2:0]                    state;
  esc_pkg::mode_t                mode;
  esc_pkg::dir_t                 dir;
  esc_pkg::floor_t               cur_floor;
  logic [QW-1:0]                 qlen;
  esc_pkg::floor_t               head;
  esc_pkg::floor_t               req_f;
  logic [AW-1:0]                 cnt;
  logic                          more;
  logic                          vld;
  logic [AW-1:0]                 didx;
  esc_pkg::floor_t               rd_data;
  esc_pkg::floor_t               prev;
  logic                          dup;
  logic                          end_found;
  logic [AW-1:0]                 end_idx;
  logic                          pos_found;
  logic [AW-1:0]                 pos_idx;
  logic                          case_a;
  logic [QW-1:0]                 pos_r;
  esc_pkg::result_t              res [esc_pkg::MAX_RES];
  logic [esc_pkg::RCNT_W-1:0]    rcount;
  logic [esc_pkg::RCNT_W-1:0]    oidx;

  esc_pkg::floor_t               queue_mem [FLOORS];

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  esc_pkg::floor_t               wr_data;

  logic [QW-1:0]                 last_q;
  logic                          end_here;
  logic                          in_seg;
  logic                          pos_hit;
  logic [QW-1:0]                 end_len;
  logic [QW-1:0]                 ins_pos;
  esc_pkg::floor_t               step_up;
  esc_pkg::floor_t               step_dn;
  esc_pkg::dir_t                 adv_dir;
  esc_pkg::floor_t               adv_cur;
  logic                          adv_ok;
  logic                          was_moving;
  logic [1:0]                    base;
  logic [1:0]                    after;

  always_comb begin
    last_q   = qlen - QW'(1);
    end_here = (didx != '0) && !esc_pkg::sweep_gt(rd_data, prev, dir);
    in_seg   = !end_found && !end_here;
    if (case_a) begin
      pos_hit = in_seg && !esc_pkg::sweep_gt(req_f, rd_data, dir);
    end else begin
      pos_hit = !in_seg && !esc_pkg::sweep_gt(rd_data, req_f, dir);
    end
    end_len = end_found ? QW'(end_idx) : qlen;
    if (pos_found) begin
      ins_pos = QW'(pos_idx);
    end else begin
      ins_pos = case_a ? end_len : qlen;
    end
  end

  always_comb begin
    step_up    = (cur_floor < TOP_FLOOR) ? cur_floor + 5'd1 : TOP_FLOOR;
    step_dn    = (cur_floor > 5'd1) ? cur_floor - 5'd1 : 5'd1;
    adv_dir    = (cur_floor > head) ? esc_pkg::DIR_DOWN : esc_pkg::DIR_UP;
    was_moving = (mode == esc_pkg::MODE_MOVE);
    if (was_moving) begin
      adv_cur = (adv_dir == esc_pkg::DIR_DOWN) ? step_dn : step_up;
    end else begin
      adv_cur = cur_floor;
    end
    adv_ok = (qlen != '0) && (mode == esc_pkg::MODE_TASK || was_moving);
    base   = rcount[1:0];
    after  = was_moving ? base + 2'd1 : base;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      ST_DECIDE: begin
        if (!dup && qlen != QFULL && ins_pos == qlen) begin
          wr_en   = 1'b1;
          wr_addr = qlen[AW-1:0];
          wr_data = req_f;
        end
      end
      ST_SHIFT_UP: begin
        wr_en   = vld;
        wr_addr = didx + AW'(1);
      end
      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = req_f;
      end
      ST_SHIFT_DOWN: begin
        wr_en   = vld;
        wr_addr = didx - AW'(1);
      end
      ST_IDLE, ST_SCAN, ST_ADVANCE, ST_EMIT: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= queue_mem[cnt];
    if (wr_en) begin
      queue_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= esc_pkg::MODE_WAIT;
      dir       <= esc_pkg::DIR_STOP;
      cur_floor <= 5'd1;
      qlen      <= '0;
      more      <= 1'b0;
      vld       <= 1'b0;
      rcount    <= '0;
      oidx      <= '0;
    end else begin
      vld  <= more;
      didx <= cnt;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rcount    <= '0;
            oidx      <= '0;
            req_f     <= req_floor;
            dup       <= 1'b0;
            end_found <= 1'b0;
            pos_found <= 1'b0;
            case_a    <= !esc_pkg::sweep_gt(cur_floor, req_floor, dir);
            state     <= ST_EMIT;
            if (cmd == esc_pkg::CMD_REQUEST) begin
              if (req_floor != '0 && req_floor <= TOP_FLOOR) begin
                mode <= esc_pkg::MODE_TASK;
                if (req_floor == cur_floor) begin
                  res[0] <= '{kind: esc_pkg::EV_AT, floor: cur_floor};
                  res[1] <= '{kind: (dir != esc_pkg::DIR_STOP) ? esc_pkg::EV_STOP
                                                                : esc_pkg::EV_LOCK,
                              floor: cur_floor};
                  rcount <= 3'd2;
                  mode   <= esc_pkg::MODE_ARRIVE;
                end else if (qlen == '0) begin
                  state <= ST_DECIDE;
                end else begin
                  state <= ST_SCAN;
                  cnt   <= '0;
                  more  <= 1'b1;
                end
              end
            end else if (cmd == esc_pkg::CMD_MOVED) begin
              state <= ST_ADVANCE;
            end else if (cmd == esc_pkg::CMD_READY) begin
              if (mode == esc_pkg::MODE_ARRIVE || mode == esc_pkg::MODE_MOVE) begin
                if (qlen == '0) begin
                  mode <= esc_pkg::MODE_WAIT;
                  dir  <= esc_pkg::DIR_STOP;
                end else begin
                  mode  <= esc_pkg::MODE_TASK;
                  state <= ST_ADVANCE;
                end
              end
            end
          end
        end
        ST_SCAN: begin
          if (more) begin
            cnt <= cnt + AW'(1);
            if (QW'(cnt) == last_q) begin
              more <= 1'b0;
            end
          end
          if (vld) begin
            prev <= rd_data;
            if (rd_data == req_f) begin
              dup <= 1'b1;
            end
            if (!end_found && end_here) begin
              end_found <= 1'b1;
              end_idx   <= didx;
            end
            if (!pos_found && pos_hit) begin
              pos_found <= 1'b1;
              pos_idx   <= didx;
            end
            if (QW'(didx) == last_q) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          state <= ST_ADVANCE;
          if (!dup) begin
            res[base] <= '{kind: esc_pkg::EV_BUTTON, floor: req_f};
            rcount    <= rcount + 3'd1;
            if (qlen != QFULL) begin
              pos_r <= ins_pos;
              if (ins_pos == qlen) begin
                qlen <= qlen + QW'(1);
                if (ins_pos == '0) begin
                  head <= req_f;
                end
              end else begin
                state <= ST_SHIFT_UP;
                cnt   <= last_q[AW-1:0];
                more  <= 1'b1;
              end
            end
          end
        end
        ST_SHIFT_UP: begin
          if (more) begin
            cnt <= cnt - AW'(1);
            if (QW'(cnt) == pos_r) begin
              more <= 1'b0;
            end
          end
          if (vld && QW'(didx) == pos_r) begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          qlen  <= qlen + QW'(1);
          state <= ST_ADVANCE;
          if (pos_r == '0) begin
            head <= req_f;
          end
        end
        ST_ADVANCE: begin
          state <= ST_EMIT;
          if (adv_ok) begin
            mode      <= esc_pkg::MODE_MOVE;
            dir       <= adv_dir;
            cur_floor <= adv_cur;
            if (was_moving) begin
              res[base] <= '{kind: esc_pkg::EV_AT, floor: adv_cur};
            end
            if (adv_cur != head) begin
              res[after] <= '{kind: esc_pkg::EV_MOVE, floor: adv_cur};
              rcount     <= rcount + (was_moving ? 3'd2 : 3'd1);
            end else begin
              res[after]         <= '{kind: esc_pkg::EV_AT, floor: adv_cur};
              res[after + 2'd1]  <= '{kind: esc_pkg::EV_STOP, floor: adv_cur};
              rcount             <= rcount + (was_moving ? 3'd3 : 3'd2);
              mode               <= esc_pkg::MODE_ARRIVE;
              qlen               <= qlen - QW'(1);
              if (qlen > QW'(1)) begin
                state <= ST_SHIFT_DOWN;
                cnt   <= AW'(1);
                more  <= 1'b1;
              end
            end
          end
        end
        ST_SHIFT_DOWN: begin
          if (more) begin
            cnt <= cnt + AW'(1);
            if (QW'(cnt) == qlen) begin
              more <= 1'b0;
            end
          end
          if (vld) begin
            if (didx == AW'(1)) begin
              head <= rd_data;
            end
            if (QW'(didx) == qlen) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          oidx <= oidx + 3'd1;
          if (rcount == '0 || oidx == rcount - 3'd1) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign busy        = (state != ST_IDLE);
  assign strobe      = (state == ST_EMIT) && (rcount != '0);
  assign event_kind  = res[oidx[1:0]].kind;
  assign event_floor = res[oidx[1:0]].floor;
  assign last        = strobe && (oidx == rcount - 3'd1);

endmodule

### sv/esc_checker.sv
// Port-level checker for the elevator scan controller, bound to the controller module.
// Depends on esc_pkg and on the assertion macros in elevator_scan_controller_assert.svh.
`include "elevator_scan_controller_assert.svh"

module esc_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            strobe,
  input esc_pkg::kind_t  event_kind,
  input logic            last
);

  // Every command transfer makes the block busy in the cycle after it.
  `ESC_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `ESC_ASSERT_IMP(a_strobe_busy, strobe, busy)
  // The results of one command come in consecutive cycles and then stop.
  `ESC_ASSERT_NXT(a_run_contig, strobe && !last, strobe)
  `ESC_ASSERT_NXT(a_run_ends, strobe && last, !strobe)
  `ESC_ASSERT_IMP(a_kind_legal, strobe, event_kind <= esc_pkg::EV_LOCK)

endmodule

bind elevator_scan_controller esc_checker u_esc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .event_kind (event_kind),
  .last       (last)
);
